// ===== design/calclk_pkg.sv =====
// Shared types, constants and the month length function of the calendar clock.
// Used by calclk_step, calendar_clock_counter_top and the testbench; no dependencies.
`timescale 1ns / 1ps

package calclk_pkg;

    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 4;

    localparam int TDATA_W = 32;

    localparam logic [SEC_W-1:0]   SEC_LAST   = SEC_W'(59);
    localparam logic [MIN_W-1:0]   MIN_LAST   = MIN_W'(59);
    localparam logic [HOUR_W-1:0]  HOUR_LAST  = HOUR_W'(23);
    localparam logic [MONTH_W-1:0] MONTH_LAST = MONTH_W'(12);
    localparam logic [YEAR_W-1:0]  YEAR_RESET = YEAR_W'(3);

    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
    localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
    localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
    localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_LOAD     = 2'd1,
        OP_INC_YEAR = 2'd2
    } calclk_op_t;

    // Packed so that the second sits in the lowest bits, as on the stream buses.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } calclk_time_t;

    localparam int TIME_W = $bits(calclk_time_t);

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                     input logic [YEAR_W-1:0] year);
        logic [DAY_W-1:0] len;
        len = DAY_W'(31);
        if (month == MONTH_APR || month == MONTH_JUN || month == MONTH_SEP ||
            month == MONTH_NOV) begin
            len = DAY_W'(30);
        end else if (month == MONTH_FEB) begin
            if (year != '0 && year[1:0] == 2'b00) begin
                len = DAY_W'(29);
            end else begin
                len = DAY_W'(28);
            end
        end
        return len;
    endfunction

endpackage

// ===== design/calclk_step.sv =====
// Next-value logic of the calendar: applies one operation to the current time and date.
// Depends on calclk_pkg.
`timescale 1ns / 1ps

module calclk_step (
    input  logic [1:0]                 op,
    input  calclk_pkg::calclk_time_t   load,
    input  calclk_pkg::calclk_time_t   cur,
    input  logic                       sec_pulse,
    output calclk_pkg::calclk_time_t   nxt
);
    import calclk_pkg::*;

    logic [DAY_W:0]   day_inc;
    logic [DAY_W-1:0] day_len;
    calclk_time_t     adv;

    always_comb begin
        day_len = month_length(cur.month, cur.year);
        day_inc = {1'b0, cur.day} + (DAY_W+1)'(1);
        adv     = cur;
        if (cur.second < SEC_LAST) begin
            adv.second = cur.second + SEC_W'(1);
        end else begin
            adv.second = '0;
            if (cur.minute < MIN_LAST) begin
                adv.minute = cur.minute + MIN_W'(1);
            end else begin
                adv.minute = '0;
                if (cur.hour < HOUR_LAST) begin
                    adv.hour = cur.hour + HOUR_W'(1);
                end else begin
                    adv.hour = '0;
                    if (day_inc > {1'b0, day_len}) begin
                        adv.day = DAY_W'(1);
                        if (cur.month >= MONTH_LAST) begin
                            adv.month = MONTH_W'(1);
                            adv.year  = cur.year + YEAR_W'(1);
                        end else begin
                            adv.month = cur.month + MONTH_W'(1);
                        end
                    end else begin
                        adv.day = day_inc[DAY_W-1:0];
                    end
                end
            end
        end
    end

    always_comb begin
        nxt = cur;
        case (op)
            OP_TICK: begin
                if (sec_pulse) begin
                    nxt = adv;
                end
            end
            OP_LOAD: begin
                nxt = load;
                if (load.month > MONTH_LAST) begin
                    nxt.month = cur.month;
                end
            end
            OP_INC_YEAR: begin
                nxt.year = cur.year + YEAR_W'(1);
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ===== design/calendar_clock_counter_top.sv =====
// Top level of the calendar clock: stream ports, input register, calendar state and result register.
// Depends on calclk_pkg and calclk_step.
`timescale 1ns / 1ps

// Calendar clock that keeps second, minute, hour, day, month and a four-bit year. Each input
// transfer carries one operation in s_axis_tuser (tick, load, increment year) and yields exactly
// one result transfer with the time after it; m_axis_tuser flags a tick that completed a second.
// An item passes through the input register and then the result register, and a new item is
// taken every cycle while the result side keeps up. After reset the state holds zero in second,
// minute, hour, day and month; the year resets to three.
module calendar_clock_counter_top #(
    parameter int TICKS_PER_SECOND = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: load_second, load_minute, load_hour, load_day, load_month, load_year.
    input  logic [calclk_pkg::TDATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: operation.
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: second, minute, hour, day, month, year.
    output logic [calclk_pkg::TDATA_W-1:0]  m_axis_tdata,
    // Fields from bit 0: second_advanced.
    output logic [0:0]                      m_axis_tuser
);
    import calclk_pkg::*;

    localparam int TICK_W = (TICKS_PER_SECOND > 2) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(TICKS_PER_SECOND - 1);

    logic               in_valid_reg;
    logic [1:0]         in_op_reg;
    calclk_time_t       in_load_reg;
    calclk_time_t       cal_reg;
    calclk_time_t       cal_next;
    logic [TICK_W-1:0]  tick_reg;
    logic [TICK_W-1:0]  tick_next;
    logic               out_valid_reg;
    calclk_time_t       out_time_reg;
    logic               out_adv_reg;
    logic               advance;
    logic               sec_pulse;
    logic               tick_done;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    assign tick_done = (tick_reg == TICK_LAST);
    assign sec_pulse = (in_op_reg == OP_TICK) && tick_done;

    always_comb begin
        tick_next = tick_reg;
        case (in_op_reg)
            OP_TICK: begin
                tick_next = tick_done ? '0 : tick_reg + TICK_W'(1);
            end
            OP_LOAD: begin
                tick_next = '0;
            end
            default: begin
                tick_next = tick_reg;
            end
        endcase
    end

    calclk_step u_step (
        .op        (in_op_reg),
        .load      (in_load_reg),
        .cur       (cal_reg),
        .sec_pulse (sec_pulse),
        .nxt       (cal_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_op_reg   <= s_axis_tuser;
            in_load_reg <= calclk_time_t'(s_axis_tdata[TIME_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg       <= '{year: YEAR_RESET, default: '0};
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                cal_reg  <= cal_next;
                tick_reg <= tick_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_time_reg <= cal_next;
            out_adv_reg  <= sec_pulse;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {(TDATA_W - TIME_W)'(0), out_time_reg};
    assign m_axis_tuser[0] = out_adv_reg;

endmodule

// ===== design/calclk_checker.sv =====
// Port-level checks of the calendar clock and their bind to the top level.
// Depends on calendar_clock_counter_top.
`timescale 1ns / 1ps

module calclk_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // No result is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result transfer changed");

    // An empty result register never blocks the input side.
    a_in_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result stage");

    // A completed second always leaves the second in range.
    a_sec_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[5:0] <= 6'd59)
        else $error("second out of range after advance");

endmodule

bind calendar_clock_counter_top calclk_checker u_calclk_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/tb_calendar_clock_counter_top.sv =====
// Self-checking testbench for calendar_clock_counter_top: a queue-fed stream driver and
// a stalling monitor check every result against an in-bench calendar predictor.
// Depends on calclk_pkg and the calendar_clock_counter_top RTL.
`timescale 1ns / 1ps

module tb_calendar_clock_counter_top;
    import calclk_pkg::*;

    localparam int TICKS_PER_SEC = 16;
    localparam int DIRECTED_ITEMS = 24;
    localparam int RANDOM_ITEMS = 1950;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0]   op;
        calclk_time_t load;
        logic         drain_first;
    } clock_cmd_t;

    typedef struct packed {
        calclk_time_t stamp;
        logic         advanced;
    } clock_reading_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_W-1:0]     s_axis_tdata = '0;
    logic [1:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]     m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    clock_cmd_t     pending_cmds[$];
    clock_reading_t expected_readings[$];
    clock_cmd_t     cmd_on_bus;

    calclk_time_t   clock_now;
    logic [3:0]     subsec_ticks;

    int gap_left = 0;
    int stall_left = 0;
    int mismatches = 0;
    int results_seen = 0;
    int n_ticks = 0;
    int n_carries = 0;
    int n_month_turns = 0;
    int n_year_turns = 0;
    int n_loads = 0;
    int n_month_kept = 0;
    int n_year_incs = 0;
    int n_unknown = 0;

    calendar_clock_counter_top #(
        .TICKS_PER_SECOND(TICKS_PER_SEC)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int days_in_month(input logic [3:0] mon, input logic [3:0] yr);
        if (mon == MONTH_APR || mon == MONTH_JUN || mon == MONTH_SEP || mon == MONTH_NOV) begin
            return 30;
        end
        if (mon == MONTH_FEB) begin
            return (yr != 4'd0 && yr[1:0] == 2'b00) ? 29 : 28;
        end
        return 31;
    endfunction

    function automatic clock_reading_t step_clock(input clock_cmd_t cmd);
        clock_reading_t r;
        int t;
        r.advanced = 1'b0;
        case (cmd.op)
            OP_TICK: begin
                n_ticks++;
                t = int'(subsec_ticks) + 1;
                if (t >= TICKS_PER_SEC) begin
                    subsec_ticks = '0;
                    r.advanced = 1'b1;
                    n_carries++;
                    if (clock_now.second < SEC_LAST) begin
                        clock_now.second = clock_now.second + SEC_W'(1);
                    end else begin
                        clock_now.second = '0;
                        if (clock_now.minute < MIN_LAST) begin
                            clock_now.minute = clock_now.minute + MIN_W'(1);
                        end else begin
                            clock_now.minute = '0;
                            if (clock_now.hour < HOUR_LAST) begin
                                clock_now.hour = clock_now.hour + HOUR_W'(1);
                            end else begin
                                clock_now.hour = '0;
                                if (int'(clock_now.day) + 1 >
                                    days_in_month(clock_now.month, clock_now.year)) begin
                                    clock_now.day = 5'd1;
                                    n_month_turns++;
                                    if (clock_now.month >= MONTH_LAST) begin
                                        clock_now.month = 4'd1;
                                        clock_now.year = clock_now.year + YEAR_W'(1);
                                        n_year_turns++;
                                    end else begin
                                        clock_now.month = clock_now.month + MONTH_W'(1);
                                    end
                                end else begin
                                    clock_now.day = clock_now.day + DAY_W'(1);
                                end
                            end
                        end
                    end
                end else begin
                    subsec_ticks = t[3:0];
                end
            end
            OP_LOAD: begin
                n_loads++;
                clock_now.second = cmd.load.second;
                clock_now.minute = cmd.load.minute;
                clock_now.hour = cmd.load.hour;
                clock_now.day = cmd.load.day;
                if (cmd.load.month <= MONTH_LAST) begin
                    clock_now.month = cmd.load.month;
                end else begin
                    n_month_kept++;
                end
                clock_now.year = cmd.load.year;
                subsec_ticks = '0;
            end
            OP_INC_YEAR: begin
                n_year_incs++;
                clock_now.year = clock_now.year + YEAR_W'(1);
            end
            default: begin
                n_unknown++;
            end
        endcase
        r.stamp = clock_now;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic add_op(input logic [1:0] op);
        clock_cmd_t cmd;
        cmd.op = op;
        cmd.load = calclk_time_t'(TIME_W'($urandom));
        cmd.drain_first = 1'b0;
        pending_cmds.push_back(cmd);
    endtask

    task automatic add_load(input int sec, input int mnt, input int hr, input int dy,
                            input int mon, input int yr, input logic drain);
        clock_cmd_t cmd;
        cmd.op = OP_LOAD;
        cmd.load.second = SEC_W'(sec);
        cmd.load.minute = MIN_W'(mnt);
        cmd.load.hour = HOUR_W'(hr);
        cmd.load.day = DAY_W'(dy);
        cmd.load.month = MONTH_W'(mon);
        cmd.load.year = YEAR_W'(yr);
        cmd.drain_first = drain;
        pending_cmds.push_back(cmd);
    endtask

    task automatic check_field(input string what, input int idx, input int want,
                               input int got);
        if (want != got) begin
            if (mismatches < 10) begin
                $display("result %0d %s: expected %0d, got %0d", idx, what, want, got);
            end
            mismatches++;
        end
    endtask

    task automatic build_random_part();
        int r, sec, mnt, hr, dy, mon, yr, len, n;
        while (pending_cmds.size() < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                sec = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(57, 63);
                r = $urandom_range(0, 99);
                mnt = (r < 50) ? 59 : (r < 65) ? $urandom_range(60, 63) :
                      (r < 80) ? 58 : $urandom_range(0, 63);
                r = $urandom_range(0, 99);
                hr = (r < 50) ? 23 : (r < 65) ? $urandom_range(24, 31) :
                     (r < 80) ? 22 : $urandom_range(0, 31);
                r = $urandom_range(0, 99);
                mon = (r < 25) ? 2 : (r < 45) ? 12 : (r < 55) ? $urandom_range(13, 15) :
                      (r < 60) ? 0 : $urandom_range(1, 12);
                r = $urandom_range(0, 99);
                yr = (r < 30) ? 15 : (r < 50) ? 4 * $urandom_range(0, 3) : $urandom_range(0, 15);
                len = (mon > 12) ? 31 : days_in_month(mon[3:0], yr[3:0]);
                r = $urandom_range(0, 99);
                dy = (r < 50) ? len : (r < 65) ? len - 1 : (r < 75) ? $urandom_range(len, 31) :
                     (r < 85) ? 0 : $urandom_range(0, 31);
                add_load(sec, mnt, hr, dy, mon, yr, $urandom_range(0, 49) == 0);
                n = 16 * $urandom_range(1, 4) + $urandom_range(0, 15);
                repeat (n) begin
                    r = $urandom_range(0, 39);
                    add_op((r == 0) ? OP_INC_YEAR : (r == 1) ? OP_UNKNOWN : OP_TICK);
                end
            end else if (r < 80) begin
                repeat ($urandom_range(1, 8)) begin
                    add_op(2'($urandom_range(0, 3)));
                end
            end else if (r < 90) begin
                repeat ($urandom_range(1, 18)) begin
                    add_op(OP_INC_YEAR);
                end
            end else begin
                repeat ($urandom_range(1, 40)) begin
                    add_op(OP_TICK);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        logic took;
        took = s_axis_tvalid && s_axis_tready;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (took) begin
                expected_readings.push_back(step_clock(cmd_on_bus));
                gap_left = ((($time / 10) / 700) % 4 == 1) ? 0 : pick_gap();
            end
            if (!s_axis_tvalid || took) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_cmds.size() == 0 ||
                             (pending_cmds[0].drain_first && expected_readings.size() != 0)) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    cmd_on_bus = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= cmd_on_bus.op;
                    s_axis_tdata <= {{(TDATA_W - TIME_W){1'b0}}, cmd_on_bus.load};
                end
            end
        end
    end

    always @(posedge aclk) begin
        clock_reading_t want;
        calclk_time_t got;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[TIME_W-1:0];
                if (expected_readings.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("result %0d arrived with nothing expected: tdata %h",
                                 results_seen, m_axis_tdata);
                    end
                    mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    check_field("second", results_seen, int'(want.stamp.second),
                                int'(got.second));
                    check_field("minute", results_seen, int'(want.stamp.minute),
                                int'(got.minute));
                    check_field("hour", results_seen, int'(want.stamp.hour), int'(got.hour));
                    check_field("day", results_seen, int'(want.stamp.day), int'(got.day));
                    check_field("month", results_seen, int'(want.stamp.month),
                                int'(got.month));
                    check_field("year", results_seen, int'(want.stamp.year), int'(got.year));
                    check_field("second_advanced", results_seen, int'(want.advanced),
                                int'(m_axis_tuser[0]));
                end
                results_seen++;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = ((($time / 10) / 450) % 3 == 0) ? 0 : pick_gap();
            end
        end
    end

    initial begin
        clock_now = '0;
        clock_now.year = YEAR_RESET;
        subsec_ticks = '0;

        add_op(OP_TICK);
        add_op(OP_UNKNOWN);
        add_op(OP_INC_YEAR);
        add_load(63, 63, 31, 31, 15, 15, 1'b0);
        add_load(0, 0, 0, 0, 0, 0, 1'b0);
        add_load(5, 5, 5, 5, 5, 15, 1'b0);
        add_op(OP_INC_YEAR);
        add_load(59, 59, 23, 31, 12, 15, 1'b1);
        repeat (TICKS_PER_SEC) begin
            add_op(OP_TICK);
        end
        build_random_part();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_readings.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (expected_readings.size() != 0) begin
            mismatches++;
        end
        $display("Checked %0d results: %0d ticks with %0d second carries, %0d day and %0d year",
                 results_seen, n_ticks, n_carries, n_month_turns, n_year_turns);
        $display("rollovers; %0d loads (%0d with month kept), %0d year increments, %0d unknown ops.",
                 n_loads, n_month_kept, n_year_incs, n_unknown);
        if (mismatches == 0) begin
            $display("tb_calendar_clock_counter_top OK");
        end else begin
            $display("tb_calendar_clock_counter_top NOT OK");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d items pending and %0d results outstanding.",
                 pending_cmds.size(), expected_readings.size());
        $display("tb_calendar_clock_counter_top NOT OK");
        $finish;
    end

endmodule
